// ===== hw/rtl/blrast_pkg.sv =====
// ----------------------------------------------------------------------------
// blrast_pkg
// Shared constants and status types for the Bresenham line rasterizer.
// ----------------------------------------------------------------------------
package blrast_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int COLOR_BITS         = 16;
   localparam int SCREEN_BITS        = 11;
   localparam int CSR_INDEX_BITS     = 2;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 11'd466;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 11'd466;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

   // request kinds
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_START = 1'b1;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic pop;
      logic emit;
      logic emit_last;
   } back_status_type;

endpackage

// ===== hw/rtl/bresenham_line_rasterizer_unit.sv =====
// path: an accepted beat is written into a queue entry; the back end pops it and
// registers any pixel it yields in the output register that drives rsp
// throughput: one beat per cycle unless rsp stalls; one back-end error update per cycle
// a two-entry queue decouples request acceptance from the stepping back end
// reset: synchronous, clears queue, line busy flag and output valid; screen size
// registers return to 466 x 466
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer_unit
// All-octant Bresenham line stepper with screen clipping flags and a
// register write port for the screen size.
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer_unit #(
   parameter int COORD_BITS = blrast_pkg::COORD_BITS_DEFAULT,
   parameter int REQ_W      = ((4 * COORD_BITS + blrast_pkg::COLOR_BITS + 7) / 8) * 8,
   parameter int RSP_W      = ((2 * COORD_BITS + blrast_pkg::COLOR_BITS + 7) / 8) * 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // start_x, start_y, end_x, end_y, line_color
   input  logic [REQ_W-1:0]                      req_tdata,
   // req_type
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // pixel_x, pixel_y, pixel_color
   output logic [RSP_W-1:0]                      rsp_tdata,
   // in_view
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [blrast_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [blrast_pkg::SCREEN_BITS-1:0]    csr_data
);

   localparam int ENTRY_W = 6 * COORD_BITS + 20;

   logic [blrast_pkg::SCREEN_BITS-1:0] width_ff, width_in;
   logic [blrast_pkg::SCREEN_BITS-1:0] height_ff, height_in;

   logic                         push_valid, push_ready, pop_valid, pop_ready;
   logic [ENTRY_W-1:0]           push_data, pop_data;
   blrast_pkg::queue_status_type q_stat;
   blrast_pkg::back_status_type  b_stat;

   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            blrast_pkg::REG_SCREEN_WIDTH:  width_in  = csr_data;
            blrast_pkg::REG_SCREEN_HEIGHT: height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= blrast_pkg::SCREEN_WIDTH_RESET;
         height_ff <= blrast_pkg::SCREEN_HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   blrast_front #(
      .COORD_BITS (COORD_BITS),
      .REQ_W      (REQ_W),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   blrast_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data),
      .status     (q_stat)
   );

   blrast_back #(
      .COORD_BITS (COORD_BITS),
      .ENTRY_W    (ENTRY_W),
      .RSP_W      (RSP_W)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .screen_width  (width_ff),
      .screen_height (height_ff),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .status        (b_stat)
   );

   // queue can never claim full and empty together
   assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue full and empty at once");

   // back end only pops an entry that exists
   assert property (@(posedge clock) disable iff (reset)
      b_stat.pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // emitting the final pixel leaves the line idle
   assert property (@(posedge clock) disable iff (reset)
      (b_stat.emit && b_stat.emit_last) |=> !b_stat.busy)
      else $error("busy after last pixel");

   // a pixel beat always follows an emit
   assert property (@(posedge clock) disable iff (reset)
      b_stat.emit |=> rsp_tvalid)
      else $error("emitted pixel not presented");

endmodule

// ===== hw/rtl/blrast_front.sv =====
// ----------------------------------------------------------------------------
// blrast_front
// Accepts request beats, splits the payload and precomputes the line
// deltas and step directions for start requests.
// ----------------------------------------------------------------------------
module blrast_front #(
   parameter int COORD_BITS = blrast_pkg::COORD_BITS_DEFAULT,
   parameter int REQ_W      = 64,
   parameter int ENTRY_W    = 6 * COORD_BITS + 20
) (
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               req_tuser,
   output logic               push_valid,
   input  logic               push_ready,
   output logic [ENTRY_W-1:0] push_data
);

   localparam int C = COORD_BITS;

   logic [C-1:0]                        sx, sy, ex, ey;
   logic [blrast_pkg::COLOR_BITS-1:0]   color;
   logic signed [C:0]                   dx_w, dy_w;
   logic [C-1:0]                        delta_x;
   logic [C:0]                          delta_y_neg;
   logic                                step_x_neg, step_y_neg;

   assign sx    = req_tdata[C-1:0];
   assign sy    = req_tdata[2*C-1:C];
   assign ex    = req_tdata[3*C-1:2*C];
   assign ey    = req_tdata[4*C-1:3*C];
   assign color = req_tdata[4*C+blrast_pkg::COLOR_BITS-1:4*C];

   assign dx_w = $signed({ex[C-1], ex}) - $signed({sx[C-1], sx});
   assign dy_w = $signed({ey[C-1], ey}) - $signed({sy[C-1], sy});

   // step is negative unless the target lies strictly ahead
   assign step_x_neg = dx_w[C] || (dx_w == '0);
   assign step_y_neg = dy_w[C] || (dy_w == '0);

   always_comb begin
      logic [C:0] abs_x;
      abs_x       = dx_w[C] ? (-dx_w) : dx_w;
      delta_x     = abs_x[C-1:0];
      delta_y_neg = dy_w[C] ? dy_w : (-dy_w);
   end

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign push_data  = {step_y_neg, step_x_neg, delta_y_neg, delta_x, color,
                        ey, ex, sy, sx, req_tuser};

endmodule

// ===== hw/rtl/blrast_queue.sv =====
// ----------------------------------------------------------------------------
// blrast_queue
// Two-entry register queue between the request front and the stepping back.
// ----------------------------------------------------------------------------
module blrast_queue #(
   parameter int WIDTH = 92
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push_valid,
   output logic                         push_ready,
   input  logic [WIDTH-1:0]             push_data,
   output logic                         pop_valid,
   input  logic                         pop_ready,
   output logic [WIDTH-1:0]             pop_data,
   output blrast_pkg::queue_status_type status
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/blrast_back.sv =====
// ----------------------------------------------------------------------------
// blrast_back
// Holds the line state, performs one Bresenham error update per tick and
// registers the emitted pixel for the result channel.
// ----------------------------------------------------------------------------
module blrast_back #(
   parameter int COORD_BITS = blrast_pkg::COORD_BITS_DEFAULT,
   parameter int ENTRY_W    = 6 * COORD_BITS + 20,
   parameter int RSP_W      = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                pop_valid,
   output logic                                pop_ready,
   input  logic [ENTRY_W-1:0]                  pop_data,
   input  logic [blrast_pkg::SCREEN_BITS-1:0]  screen_width,
   input  logic [blrast_pkg::SCREEN_BITS-1:0]  screen_height,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_W-1:0]                    rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output blrast_pkg::back_status_type         status
);

   localparam int C  = COORD_BITS;
   localparam int EW = COORD_BITS + 3;
   localparam int CW = (COORD_BITS - 1 > blrast_pkg::SCREEN_BITS) ?
                       (COORD_BITS - 1) : blrast_pkg::SCREEN_BITS;
   localparam int CB = blrast_pkg::COLOR_BITS;

   // queue entry fields
   logic          q_type;
   logic [C-1:0]  q_sx, q_sy, q_ex, q_ey, q_dx;
   logic [CB-1:0] q_color;
   logic [C:0]    q_dyn;
   logic          q_sxn, q_syn;

   assign {q_syn, q_sxn, q_dyn, q_dx, q_color, q_ey, q_ex, q_sy, q_sx, q_type} = pop_data;

   // line state
   logic          busy_ff, busy_in;
   logic [C-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [C-1:0]  tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic          sxn_ff, sxn_in, syn_ff, syn_in;
   logic [C-1:0]  dx_ff, dx_in;
   logic [C:0]    dyn_ff, dyn_in;
   logic [EW-1:0] err_ff, err_in;
   logic [CB-1:0] color_ff, color_in;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic [C-1:0]  out_x_ff, out_y_ff;
   logic [CB-1:0] out_color_ff;
   logic          out_view_ff, out_view_in;
   logic          out_last_ff, out_last_in;

   logic              pop, emit, last;
   logic signed [EW:0] e2, dyn_cmp, dx_cmp;
   logic              move_x, move_y;

   assign pop_ready = !out_valid_ff || rsp_tready;
   assign pop       = pop_valid && pop_ready;
   // a tick with no line in progress is dropped
   assign emit      = pop && ((q_type == blrast_pkg::REQ_START) || busy_ff);

   assign e2      = $signed({err_ff, 1'b0});
   assign dyn_cmp = (EW + 1)'($signed(dyn_ff));
   assign dx_cmp  = (EW + 1)'(dx_ff);
   assign move_x  = (e2 >= dyn_cmp);
   assign move_y  = (e2 <= dx_cmp);

   always_comb begin
      logic [EW-1:0] add_x, add_y;
      busy_in  = busy_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      sxn_in   = sxn_ff;
      syn_in   = syn_ff;
      dx_in    = dx_ff;
      dyn_in   = dyn_ff;
      err_in   = err_ff;
      color_in = color_ff;
      add_x    = move_x ? EW'($signed(dyn_ff)) : '0;
      add_y    = move_y ? EW'(dx_ff) : '0;
      if (q_type == blrast_pkg::REQ_START) begin
         cur_x_in = q_sx;
         cur_y_in = q_sy;
         tgt_x_in = q_ex;
         tgt_y_in = q_ey;
         sxn_in   = q_sxn;
         syn_in   = q_syn;
         dx_in    = q_dx;
         dyn_in   = q_dyn;
         err_in   = EW'(q_dx) + EW'($signed(q_dyn));
         color_in = q_color;
      end else begin
         err_in = err_ff + add_x + add_y;
         if (move_x) begin
            cur_x_in = sxn_ff ? (cur_x_ff - C'(1)) : (cur_x_ff + C'(1));
         end
         if (move_y) begin
            cur_y_in = syn_ff ? (cur_y_ff - C'(1)) : (cur_y_ff + C'(1));
         end
      end
      last    = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
      busy_in = emit ? !last : busy_ff;
   end

   assign out_valid_in = emit || (out_valid_ff && !rsp_tready);
   assign out_last_in  = last;
   assign out_view_in  = !cur_x_in[C-1] && !cur_y_in[C-1] &&
                         (CW'(cur_x_in[C-2:0]) < CW'(screen_width)) &&
                         (CW'(cur_y_in[C-2:0]) < CW'(screen_height));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         tgt_x_ff     <= tgt_x_in;
         tgt_y_ff     <= tgt_y_in;
         sxn_ff       <= sxn_in;
         syn_ff       <= syn_in;
         dx_ff        <= dx_in;
         dyn_ff       <= dyn_in;
         err_ff       <= err_in;
         color_ff     <= color_in;
         out_x_ff     <= cur_x_in;
         out_y_ff     <= cur_y_in;
         out_color_ff <= color_in;
         out_view_ff  <= out_view_in;
         out_last_ff  <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'({out_color_ff, out_y_ff, out_x_ff});
   assign rsp_tuser  = out_view_ff;
   assign rsp_tlast  = out_last_ff;

   assign status.busy      = busy_ff;
   assign status.pop       = pop;
   assign status.emit      = emit;
   assign status.emit_last = last;

endmodule
